// File: hw/rtl/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IDX_PORT_W = 8;
  localparam int unsigned GEN_PORT_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_CHECK   = 2'd2
  } gha_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } gha_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_GEN,
    ST_CHK
  } gha_state_e;

endpackage

// File: hw/rtl/gha_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module gha_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/generational_handle_allocator_core.sv
// Top level of the generational handle allocator with its control sequencer.
//
// A command is transferred at a rising edge with start_i high and busy_o low.
// Create returns a handle made of a slot index and a generation; destroy
// retires a live handle and pushes its slot on a free stack unless the stack
// is full; check reports whether a handle is live. Every command yields exactly
// one result, shown for one cycle with done_o high on status_o, result_index_o and
// result_generation_o. The receiver cannot stall; it must take each result
// in the cycle it appears.
// A create that takes a never-used slot or reports full answers straight from
// the idle state; destroy and check pass through the check state, and a
// create that reuses a freed slot passes through the pop and generation states.
// The reuse case takes the longest because the stack top and then that slot's
// generation are two dependent reads of synchronous memories.
// A new command may be transferred at the same edge that takes a result.
// Reset clears the stack count, the high-water mark and the sequencer; the
// memories need no clearing, since a slot at or above the mark is never
// reported live and the stack is read only below its count.
module generational_handle_allocator_core
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned GEN_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [IDX_PORT_W-1:0] handle_index_i,
  input  logic [GEN_PORT_W-1:0] handle_generation_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [IDX_PORT_W-1:0] result_index_o,
  output logic [GEN_PORT_W-1:0] result_generation_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > IDX_PORT_W) ? CNT_W : IDX_PORT_W;
  localparam int unsigned SLOT_W = (IDX_W > IDX_PORT_W) ? IDX_W : IDX_PORT_W;
  localparam int unsigned GC_W   = (GEN_BITS > GEN_PORT_W) ? GEN_BITS : GEN_PORT_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  gha_state_e state_q, state_d;

  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [IDX_PORT_W-1:0] idx_q, idx_d;
  logic [GEN_PORT_W-1:0] gen_q, gen_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      mark_q, mark_d;
  logic                  done_q, done_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [IDX_PORT_W-1:0] ridx_q, ridx_d;
  logic [GEN_PORT_W-1:0] rgen_q, rgen_d;

  logic                  accept;
  logic                  gen_we, gen_re;
  logic [IDX_W-1:0]      gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0]   gen_wdata, gen_rdata;
  logic                  stk_we, stk_re;
  logic [IDX_W-1:0]      stk_waddr, stk_raddr;
  logic [IDX_W-1:0]      stk_rdata;

  logic [SLOT_W-1:0]     in_idx_ext, idx_q_ext, mark_ext, stk_ext;
  logic [CNT_W-1:0]      count_dec;
  logic [GC_W-1:0]       gen_rd_ext;
  logic                  in_range, live;

  assign accept     = start_i && !busy_o;
  assign busy_o     = (state_q != ST_IDLE);
  assign in_idx_ext = SLOT_W'(handle_index_i);
  assign idx_q_ext  = SLOT_W'(idx_q);
  assign mark_ext   = SLOT_W'(mark_q[IDX_W-1:0]);
  assign stk_ext    = SLOT_W'(stk_rdata);
  assign count_dec  = count_q - CNT_W'(1);
  assign gen_rd_ext = GC_W'(gen_rdata);
  assign in_range   = CMP_W'(idx_q) < CMP_W'(mark_q);
  assign live       = in_range && (gen_rd_ext == GC_W'(gen_q));

  gha_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(GEN_BITS)
  ) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (gen_we),
    .waddr_i(gen_waddr),
    .wdata_i(gen_wdata),
    .re_i   (gen_re),
    .raddr_i(gen_raddr),
    .rdata_o(gen_rdata)
  );

  gha_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(IDX_W)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(idx_q_ext[IDX_W-1:0]),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_CREATE) begin
            if (count_q != '0) begin
              state_d = ST_POP;
            end
          end else begin
            state_d = ST_CHK;
          end
        end
      end
      ST_POP:  state_d = ST_GEN;
      ST_GEN:  state_d = ST_IDLE;
      ST_CHK:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    gen_d     = gen_q;
    count_d   = count_q;
    mark_d    = mark_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ridx_d    = ridx_q;
    rgen_d    = rgen_q;
    gen_we    = 1'b0;
    gen_waddr = mark_q[IDX_W-1:0];
    gen_wdata = '0;
    gen_re    = 1'b0;
    gen_raddr = in_idx_ext[IDX_W-1:0];
    stk_we    = 1'b0;
    stk_waddr = count_q[IDX_W-1:0];
    stk_re    = 1'b0;
    stk_raddr = count_dec[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = command_i;
          idx_d = handle_index_i;
          gen_d = handle_generation_i;
          if (command_i == CMD_CREATE) begin
            if (count_q != '0) begin
              stk_re  = 1'b1;
              count_d = count_dec;
            end else if (mark_q < CAP_C) begin
              gen_we   = 1'b1;
              mark_d   = mark_q + CNT_W'(1);
              done_d   = 1'b1;
              status_d = STATUS_OK;
              ridx_d   = mark_ext[IDX_PORT_W-1:0];
              rgen_d   = '0;
            end else begin
              done_d   = 1'b1;
              status_d = STATUS_FULL;
              ridx_d   = '0;
              rgen_d   = '0;
            end
          end else begin
            gen_re = 1'b1;
          end
        end
      end
      ST_POP: begin
        gen_re    = 1'b1;
        gen_raddr = stk_rdata;
      end
      ST_GEN: begin
        done_d   = 1'b1;
        status_d = STATUS_OK;
        ridx_d   = stk_ext[IDX_PORT_W-1:0];
        rgen_d   = gen_rd_ext[GEN_PORT_W-1:0];
      end
      ST_CHK: begin
        done_d   = 1'b1;
        ridx_d   = idx_q;
        rgen_d   = gen_q;
        status_d = live ? STATUS_OK : STATUS_INVALID;
        if (live && (cmd_q == CMD_DESTROY)) begin
          gen_we    = 1'b1;
          gen_waddr = idx_q_ext[IDX_W-1:0];
          gen_wdata = gen_rdata + GEN_BITS'(1);
          if (count_q < CAP_C) begin
            stk_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      mark_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mark_q  <= mark_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    gen_q    <= gen_d;
    status_q <= status_d;
    ridx_q   <= ridx_d;
    rgen_q   <= rgen_d;
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign result_index_o      = ridx_q;
  assign result_generation_o = rgen_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("free stack count exceeds capacity");

  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_q <= CAP_C)
    else $error("high-water mark exceeds capacity");

  a_pop_then_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |=> (state_q == ST_GEN))
    else $error("stack pop not followed by generation read");

  a_full_only_when_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_FULL)) |-> ((mark_q == CAP_C) && (count_q == '0)))
    else $error("full reported while slots remain");

endmodule

// File: sim/tb_generational_handle_allocator_core.sv
// Self-checking testbench for the generational handle allocator core.
`timescale 1ns / 100ps

module tb_generational_handle_allocator_core;
  import gha_pkg::*;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned GEN_BITS = 16;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    gha_status_e           status;
    logic [IDX_PORT_W-1:0] index;
    logic [GEN_PORT_W-1:0] generation;
  } outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_PORT_W-1:0] gen;
    logic                  typed;
    outcome_t              known;
  } directed_step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [CMD_W-1:0]      command_i = '0;
  logic [IDX_PORT_W-1:0] handle_index_i = '0;
  logic [GEN_PORT_W-1:0] handle_generation_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [IDX_PORT_W-1:0] result_index_o;
  logic [GEN_PORT_W-1:0] result_generation_o;

  // Mirror of the allocator state.
  logic [GEN_PORT_W-1:0] gen_table [CAPACITY];
  logic [IDX_PORT_W-1:0] free_stack [CAPACITY];
  int unsigned           free_count = 0;
  int unsigned           high_mark = 0;

  outcome_t              results_due [$];
  outcome_t              oldest;
  logic [23:0]           live_handles [$];
  logic [23:0]           stale_handles [$];

  int unsigned transfers = 0;
  int unsigned reuse_count = 0;
  int unsigned full_count = 0;
  int unsigned rejected_count = 0;
  int unsigned dropped_pushes = 0;
  int unsigned mismatches = 0;

  directed_step_t directed_steps [22] = '{
    '{CMD_CHECK,   8'h00, 16'h0000, 1'b1, '{STATUS_INVALID, 8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'hFF, 16'hFFFF, 1'b1, '{STATUS_INVALID, 8'hFF, 16'hFFFF}},
    '{CMD_SPARE,   8'h00, 16'h0000, 1'b1, '{STATUS_INVALID, 8'h00, 16'h0000}},
    '{CMD_CREATE,  8'hFF, 16'hFFFF, 1'b1, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'h00, 16'h0000, 1'b1, '{STATUS_OK,      8'h01, 16'h0000}},
    '{CMD_CHECK,   8'h00, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CHECK,   8'h01, 16'hFFFF, 1'b1, '{STATUS_INVALID, 8'h01, 16'hFFFF}},
    '{CMD_CHECK,   8'h02, 16'h0000, 1'b1, '{STATUS_INVALID, 8'h02, 16'h0000}},
    '{CMD_SPARE,   8'h01, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'h01, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CHECK,   8'h01, 16'h0000, 1'b1, '{STATUS_INVALID, 8'h01, 16'h0000}},
    '{CMD_CHECK,   8'h01, 16'h0001, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'hAA, 16'h5555, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'h01, 16'h0001, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'h01, 16'h0002, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'h55, 16'hAAAA, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'h00, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'h00, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'h00, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_CREATE,  8'h00, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}},
    '{CMD_DESTROY, 8'hFF, 16'h0000, 1'b1, '{STATUS_INVALID, 8'hFF, 16'h0000}},
    '{CMD_CHECK,   8'h02, 16'h0000, 1'b0, '{STATUS_OK,      8'h00, 16'h0000}}
  };

  generational_handle_allocator_core #(
    .CAPACITY(CAPACITY),
    .GEN_BITS(GEN_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .command_i(command_i),
    .handle_index_i(handle_index_i),
    .handle_generation_i(handle_generation_i),
    .done_o(done_o),
    .status_o(status_o),
    .result_index_o(result_index_o),
    .result_generation_o(result_generation_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic outcome_t allocate_or_check(logic [CMD_W-1:0] cmd,
                                                 logic [IDX_PORT_W-1:0] idx,
                                                 logic [GEN_PORT_W-1:0] gen);
    outcome_t              o;
    logic [IDX_PORT_W-1:0] slot;
    bit                    live;
    o.status = STATUS_OK;
    o.index = idx;
    o.generation = gen;
    live = (idx < high_mark) && (gen_table[idx] == gen);
    case (cmd)
      CMD_CREATE: begin
        if (free_count > 0) begin
          free_count--;
          slot = free_stack[free_count];
          o.index = slot;
          o.generation = gen_table[slot];
          reuse_count++;
        end else if (high_mark < CAPACITY) begin
          gen_table[high_mark] = '0;
          o.index = high_mark[IDX_PORT_W-1:0];
          o.generation = '0;
          high_mark++;
        end else begin
          o.status = STATUS_FULL;
          o.index = '0;
          o.generation = '0;
          full_count++;
        end
      end
      CMD_DESTROY: begin
        if (live) begin
          gen_table[idx] = gen_table[idx] + 1'b1;
          if (free_count < CAPACITY) begin
            free_stack[free_count] = idx;
            free_count++;
          end else begin
            dropped_pushes++;
          end
        end else begin
          o.status = STATUS_INVALID;
        end
      end
      default: begin
        if (!live) o.status = STATUS_INVALID;
      end
    endcase
    if (o.status == STATUS_INVALID) rejected_count++;
    return o;
  endfunction

  // Drives one command after a random gap, or none during periodic bursts, and waits for its transfer.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [IDX_PORT_W-1:0] idx,
                       logic [GEN_PORT_W-1:0] gen, bit typed, outcome_t known);
    int       gap;
    outcome_t predicted;
    gap = ((transfers % 200) >= 170) ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    handle_index_i <= idx;
    handle_generation_i <= gen;
    do @(posedge clk_i); while (busy_o);
    transfers++;
    predicted = allocate_or_check(cmd, idx, gen);
    results_due.insert(results_due.size(), typed ? known : predicted);
    if (predicted.status == STATUS_OK) begin
      if (cmd == CMD_CREATE) begin
        live_handles.insert(live_handles.size(), {predicted.index, predicted.generation});
      end else if (cmd == CMD_DESTROY) begin
        stale_handles.insert(stale_handles.size(), {idx, gen});
        if (stale_handles.size() > 64) void'(stale_handles.pop_front());
      end
    end
  endtask

  task automatic churn(int count);
    int                    pick;
    int                    k;
    logic [23:0]           h;
    logic [IDX_PORT_W-1:0] idx;
    logic [GEN_PORT_W-1:0] gen;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx = $urandom_range(0, 255);
      gen = $urandom_range(0, 65535);
      if (pick < 40 || (pick < 75 && live_handles.size() == 0)) begin
        issue(CMD_CREATE, idx, gen, 1'b0, '0);
      end else if (pick < 65) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        live_handles.delete(k);
        issue(CMD_DESTROY, h[23:16], h[15:0], 1'b0, '0);
      end else if (pick < 75) begin
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        issue(CMD_CHECK, h[23:16], h[15:0], 1'b0, '0);
      end else if (pick < 83) begin
        if (stale_handles.size() > 0 && $urandom_range(0, 1)) begin
          h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
          issue($urandom_range(0, 1) ? CMD_DESTROY : CMD_CHECK, h[23:16], h[15:0],
                1'b0, '0);
        end else if (high_mark > 0) begin
          idx = $urandom_range(0, high_mark - 1);
          gen = $urandom_range(0, 1) ? gen_table[idx] + 1'b1 : gen_table[idx] - 1'b1;
          issue(CMD_DESTROY, idx, gen, 1'b0, '0);
        end else begin
          issue(CMD_DESTROY, idx, gen, 1'b0, '0);
        end
      end else if (pick < 91) begin
        issue($urandom_range(0, 1) ? CMD_CHECK : CMD_DESTROY, idx, gen, 1'b0, '0);
      end else if (pick < 95) begin
        if (live_handles.size() > 0 && $urandom_range(0, 1)) begin
          h = live_handles[$urandom_range(0, live_handles.size() - 1)];
          issue(CMD_SPARE, h[23:16], h[15:0], 1'b0, '0);
        end else begin
          issue(CMD_SPARE, idx, gen, 1'b0, '0);
        end
      end else if (high_mark > 0) begin
        idx = $urandom_range(0, high_mark - 1);
        issue($urandom_range(0, 2) ? CMD_DESTROY : CMD_CHECK, idx, gen_table[idx],
              1'b0, '0);
      end else begin
        issue(CMD_CREATE, idx, gen, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d, result_index %0d, result_generation %0d",
               status_o, result_index_o, result_generation_o);
        mismatches++;
      end else begin
        oldest = results_due.pop_front();
        if (status_o !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, status_o);
          mismatches++;
        end
        if (result_index_o !== oldest.index) begin
          $error("result_index: expected %0d, actual %0d", oldest.index, result_index_o);
          mismatches++;
        end
        if (result_generation_o !== oldest.generation) begin
          $error("result_generation: expected %0d, actual %0d", oldest.generation,
                 result_generation_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int                    slot;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i]) begin
      issue(directed_steps[i].cmd, directed_steps[i].idx, directed_steps[i].gen,
            directed_steps[i].typed, directed_steps[i].known);
    end

    churn(600);

    // Fill every slot, then keep creating against a full table.
    while (!(high_mark == CAPACITY && free_count == 0)) begin
      issue(CMD_CREATE, $urandom_range(0, 255), $urandom_range(0, 65535), 1'b0, '0);
    end
    repeat (5) issue(CMD_CREATE, $urandom_range(0, 255), $urandom_range(0, 65535), 1'b0, '0);

    churn(400);

    // Retiring one slot over and over with its current generation overflows the stack.
    slot = $urandom_range(0, high_mark - 1);
    repeat (CAPACITY + 14) issue(CMD_DESTROY, slot, gen_table[slot], 1'b0, '0);

    churn(400);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transfers: %0d slot reuses, %0d creates on a full table,",
             transfers, reuse_count, full_count);
    $display("%0d rejected handles and %0d pushes dropped on a full free stack.",
             rejected_count, dropped_pushes);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
